[hw/rtl/dedispersion_select_window_core_macros.svh]
// assertion macros for the dedispersion window selector
// expects i_clk and i_rst_n in the scope of use
`ifndef DEDISPERSION_SELECT_WINDOW_CORE_MACROS_SVH
`define DEDISPERSION_SELECT_WINDOW_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define DSWC_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);
`define DSWC_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
`else
`define DSWC_ASSERT_ALWAYS(lbl, cond, msg)
`define DSWC_ASSERT_IMP(lbl, ante, cons, msg)
`endif
`endif

[hw/rtl/dswc_pkg.sv]
// constants and types for the dedispersion window selector
// no dependencies
`default_nettype none
package dswc_pkg;
    localparam int unsigned FREQ_W    = 32;
    localparam int unsigned SHIFT_W   = 24;
    localparam int unsigned TOTAL_W   = 32;
    localparam int unsigned CFG_IDX_W = 2;

    localparam logic [31:0] FREQ_MIN  = 32'd65536;
    localparam logic [31:0] FREQ_MAX  = 32'hFFFF_FFFF;
    localparam logic [12:0] DELAY_K   = 13'd4150;
    localparam logic [31:0] REF_RESET = 32'd5767168;

    localparam logic signed [23:0] SHIFT_MAX = 24'sh7F_FFFF;
    localparam logic signed [23:0] SHIFT_MIN = 24'sh80_0000;

    localparam logic [6:0] SQ_STEPS   = 7'd32;
    localparam logic [6:0] INV_STEPS  = 7'd96;
    localparam logic [6:0] MUL_STEPS  = 7'd45;
    localparam logic [6:0] QDIV_STEPS = 7'd30;

    localparam logic [1:0] CFG_DM        = 2'd0;
    localparam logic [1:0] CFG_TIME_STEP = 2'd1;
    localparam logic [1:0] CFG_REF_FREQ  = 2'd2;
endpackage
`default_nettype wire

[hw/rtl/dswc_shift.sv]
// bit-serial dispersion shift unit: square, reciprocal, scale, divide
// depends on dswc_pkg
`default_nettype none
module dswc_shift (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic [31:0]        i_freq,
    input  wire logic [31:0]        i_dm,
    input  wire logic [31:0]        i_time_step,
    input  wire logic [31:0]        i_ref_freq,
    output logic                    o_done,
    output logic signed [23:0]      o_shift,
    output logic                    o_clip
);
    typedef enum logic [5:0] {
        U_IDLE = 6'b000001,
        U_SQ   = 6'b000010,
        U_DIV  = 6'b000100,
        U_MUL  = 6'b001000,
        U_QDIV = 6'b010000,
        U_FIN  = 6'b100000
    } t_ustate;

    t_ustate     r_st, n_st;
    logic [6:0]  r_cnt, n_cnt;
    logic        r_pass, n_pass;
    logic        r_neg, n_neg;
    logic [31:0] r_x, n_x;
    logic [63:0] r_mc, n_mc;
    logic [63:0] r_acc, n_acc;
    logic [64:0] r_rem, n_rem;
    logic [63:0] r_q, n_q;
    logic [63:0] r_mf, n_mf;
    logic [44:0] r_k, n_k;
    logic [29:0] r_n, n_n;

    logic [31:0] w_ref;
    logic        w_ref_clip;
    logic [31:0] w_t;
    logic [63:0] w_sq_sum;
    logic [64:0] w_div_sh;
    logic        w_div_ge;
    logic [63:0] w_q_next;
    logic [64:0] w_mul_sum;
    logic [32:0] w_qd_sh;
    logic        w_qd_ge;

    assign w_ref      = (i_ref_freq < dswc_pkg::FREQ_MIN) ? dswc_pkg::FREQ_MIN : i_ref_freq;
    assign w_ref_clip = (i_ref_freq < dswc_pkg::FREQ_MIN);
    assign w_t        = (i_time_step == 32'd0) ? 32'd1 : i_time_step;
    assign w_sq_sum   = r_acc + (r_x[0] ? r_mc : 64'd0);
    assign w_div_sh   = {r_rem[63:0], (r_cnt == dswc_pkg::INV_STEPS - 7'd1)};
    assign w_div_ge   = (w_div_sh >= {1'b0, r_acc});
    assign w_q_next   = {r_q[62:0], w_div_ge};
    assign w_mul_sum  = {1'b0, r_acc} + {1'b0, (r_k[0] ? r_mc : 64'd0)};
    assign w_qd_sh    = {r_rem[31:0], r_n[29]};
    assign w_qd_ge    = (w_qd_sh >= {1'b0, w_t});

    always_comb begin
        n_st = r_st; n_cnt = r_cnt; n_pass = r_pass; n_neg = r_neg;
        n_x = r_x; n_mc = r_mc; n_acc = r_acc; n_rem = r_rem; n_q = r_q;
        n_mf = r_mf; n_k = r_k; n_n = r_n;
        unique case (r_st)
            U_IDLE, U_FIN: begin
                n_st = U_IDLE;
                if (i_start) begin
                    n_x = i_freq; n_mc = {32'd0, i_freq}; n_acc = 64'd0;
                    n_pass = 1'b0; n_cnt = dswc_pkg::SQ_STEPS - 7'd1; n_st = U_SQ;
                end
            end
            U_SQ: begin
                n_acc = w_sq_sum; n_mc = {r_mc[62:0], 1'b0}; n_x = {1'b0, r_x[31:1]};
                n_cnt = r_cnt - 7'd1;
                if (r_cnt == 7'd0) begin
                    n_rem = 65'd0; n_q = 64'd0;
                    n_cnt = dswc_pkg::INV_STEPS - 7'd1; n_st = U_DIV;
                end
            end
            U_DIV: begin
                n_rem = w_div_ge ? (w_div_sh - {1'b0, r_acc}) : w_div_sh;
                n_q = w_q_next; n_cnt = r_cnt - 7'd1;
                if (r_cnt == 7'd0) begin
                    if (!r_pass) begin
                        n_mf = w_q_next; n_pass = 1'b1; n_x = w_ref;
                        n_mc = {32'd0, w_ref}; n_acc = 64'd0;
                        n_cnt = dswc_pkg::SQ_STEPS - 7'd1; n_st = U_SQ;
                    end else begin
                        n_neg = (r_mf < w_q_next);
                        n_mc  = (r_mf < w_q_next) ? (w_q_next - r_mf) : (r_mf - w_q_next);
                        n_acc = 64'd0;
                        n_k   = 45'(i_dm) * 45'(dswc_pkg::DELAY_K);
                        n_cnt = dswc_pkg::MUL_STEPS - 7'd1; n_st = U_MUL;
                    end
                end
            end
            U_MUL: begin
                n_acc = w_mul_sum[64:1]; n_k = {1'b0, r_k[44:1]}; n_cnt = r_cnt - 7'd1;
                if (r_cnt == 7'd0) begin
                    n_n = w_mul_sum[64:35]; n_rem = 65'd0;
                    n_cnt = dswc_pkg::QDIV_STEPS - 7'd1; n_st = U_QDIV;
                end
            end
            U_QDIV: begin
                n_rem = {32'd0, (w_qd_ge ? (w_qd_sh - {1'b0, w_t}) : w_qd_sh)};
                n_n = {r_n[28:0], w_qd_ge}; n_cnt = r_cnt - 7'd1;
                if (r_cnt == 7'd0) begin
                    n_st = U_FIN;
                end
            end
            default: begin
                n_st = U_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= U_IDLE;
        end else begin
            r_st <= n_st;
        end
        r_cnt <= n_cnt; r_pass <= n_pass; r_neg <= n_neg; r_x <= n_x; r_mc <= n_mc;
        r_acc <= n_acc; r_rem <= n_rem; r_q <= n_q; r_mf <= n_mf; r_k <= n_k; r_n <= n_n;
    end

    always_comb begin
        o_shift = r_n[23:0];
        o_clip  = w_ref_clip;
        if (r_neg) begin
            if (r_n > 30'd8388608) begin
                o_shift = dswc_pkg::SHIFT_MIN; o_clip = 1'b1;
            end else begin
                o_shift = 24'(30'd0 - r_n);
            end
        end else if (r_n > 30'd8388607) begin
            o_shift = dswc_pkg::SHIFT_MAX; o_clip = 1'b1;
        end
    end

    assign o_done = (r_st == U_FIN);
endmodule
`default_nettype wire

[hw/rtl/dedispersion_select_window_core.sv]
// top level of the dedispersion window selector: sweep control, window sums
// depends on dswc_pkg, dswc_shift and the assertion macro header
`default_nettype none
`include "dedispersion_select_window_core_macros.svh"
// One channel is accepted at a time. Its shift comes from a bit-serial unit that
// squares the frequency, forms floor(2^95/f^2) by restoring division, does the
// same for the reference frequency, scales by dm*4150 and divides by the time step.
// A channel that follows a held first channel needs a second pass for the
// imaginary channel. One result is held in an output register, so the next
// channel is taken while a result waits. There is no clearing pass after reset.
module dedispersion_select_window_core (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire logic [31:0]        i_freq,
    input  wire logic               i_first,
    input  wire logic               i_last,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output logic signed [23:0]      o_shift_index,
    output logic signed [23:0]      o_window_end,
    output logic [31:0]             o_window_total,
    output logic                    o_saturated,
    output logic                    o_end_of_sweep,
    input  wire logic               i_cfg_we,
    input  wire logic [1:0]         i_cfg_idx,
    input  wire logic [31:0]        i_cfg_data
);
    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_CUR  = 5'b00010,
        S_IMG  = 5'b00100,
        S_EMH  = 5'b01000,
        S_EMC  = 5'b10000
    } t_state;

    t_state             r_state, n_state;
    logic [31:0]        r_dm, r_tstep, r_ref;
    logic [31:0]        r_freq, n_freq;
    logic               r_first, n_first, r_last, n_last, r_clip, n_clip;
    logic signed [23:0] r_shift, n_shift;
    logic [31:0]        r_hfreq, n_hfreq;
    logic signed [23:0] r_hshift, n_hshift, r_s0, n_s0, r_prev, n_prev;
    logic               r_hclip, n_hclip, r_hold, n_hold;
    logic [31:0]        r_total, n_total;
    logic               n_ovalid;
    logic signed [23:0] n_oshift, n_oend;
    logic [31:0]        n_ototal;
    logic               n_osat, n_oeos;

    logic               w_accept, w_free, w_start;
    logic [31:0]        w_in_freq, w_ufreq;
    logic               w_in_clip;
    logic               w_done, w_uclip;
    logic signed [23:0] w_ushift;
    logic signed [34:0] w_c;
    logic [34:0]        w_cabs;
    logic [31:0]        w_cm;
    logic               w_cm_clip;

    logic signed [23:0] w_e_shift;
    logic signed [25:0] w_e_size, w_e_end26, w_sm_h, w_sm_c;
    logic signed [23:0] w_e_end;
    logic               w_e_clip, w_e_endclip;
    logic [31:0]        w_e_base;
    logic [25:0]        w_e_len;
    logic [32:0]        w_e_sum;

    assign o_ready   = (r_state == S_IDLE);
    assign w_accept  = i_valid && o_ready;
    assign w_free    = !o_valid || i_ready;
    assign w_in_clip = (i_freq < dswc_pkg::FREQ_MIN);
    assign w_in_freq = w_in_clip ? dswc_pkg::FREQ_MIN : i_freq;

    assign w_c    = $signed({2'b00, r_hfreq, 1'b0}) - $signed({3'b000, r_freq});
    assign w_cabs = w_c[34] ? 35'(-w_c) : 35'(w_c);
    always_comb begin
        w_cm = w_cabs[31:0];
        w_cm_clip = 1'b0;
        if (w_cabs > {3'b000, dswc_pkg::FREQ_MAX}) begin
            w_cm = dswc_pkg::FREQ_MAX; w_cm_clip = 1'b1;
        end else if (w_cabs < {3'b000, dswc_pkg::FREQ_MIN}) begin
            w_cm = dswc_pkg::FREQ_MIN; w_cm_clip = 1'b1;
        end
    end

    assign w_start = w_accept || ((r_state == S_CUR) && w_done && !r_first && r_hold);
    assign w_ufreq = w_accept ? w_in_freq : w_cm;

    dswc_shift u_shift (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_start),
        .i_freq      (w_ufreq),
        .i_dm        (r_dm),
        .i_time_step (r_tstep),
        .i_ref_freq  (r_ref),
        .o_done      (w_done),
        .o_shift     (w_ushift),
        .o_clip      (w_uclip)
    );

    always_comb begin
        w_sm_h = 26'(r_s0) - 26'(r_hshift) - 26'sd1;
        if (w_sm_h < 0) w_sm_h = 26'sd0;
        w_sm_c = 26'(r_prev) - 26'(r_shift) - 26'sd1;
        if (w_sm_c < 0) w_sm_c = 26'sd0;
    end

    always_comb begin
        if (r_state == S_EMH) begin
            w_e_shift = r_hshift; w_e_size = w_sm_h; w_e_clip = r_hclip; w_e_base = r_total;
        end else begin
            w_e_shift = r_shift; w_e_clip = r_clip;
            w_e_size  = r_first ? 26'sd0 : w_sm_c;
            w_e_base  = r_first ? 32'd0 : r_total;
        end
        w_e_end26   = 26'(w_e_shift) + w_e_size;
        w_e_endclip = (w_e_end26 > 26'(dswc_pkg::SHIFT_MAX));
        w_e_end     = w_e_endclip ? dswc_pkg::SHIFT_MAX : w_e_end26[23:0];
        w_e_len     = 26'(26'(w_e_end) - 26'(w_e_shift) + 26'sd1);
        w_e_sum     = {1'b0, w_e_base} + 33'(w_e_len);
    end

    always_comb begin
        n_state = r_state; n_freq = r_freq; n_first = r_first; n_last = r_last;
        n_clip = r_clip; n_shift = r_shift; n_hfreq = r_hfreq; n_hshift = r_hshift;
        n_s0 = r_s0; n_prev = r_prev; n_hclip = r_hclip; n_hold = r_hold; n_total = r_total;
        n_ovalid = o_valid && !i_ready;
        n_oshift = o_shift_index; n_oend = o_window_end; n_ototal = o_window_total;
        n_osat = o_saturated; n_oeos = o_end_of_sweep;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_freq = w_in_freq; n_clip = w_in_clip;
                    n_first = i_first; n_last = i_last; n_state = S_CUR;
                end
            end
            S_CUR: begin
                if (w_done) begin
                    n_shift = w_ushift; n_clip = r_clip | w_uclip;
                    if (r_first) begin
                        n_hold = 1'b0;
                        if (r_last) begin
                            n_state = S_EMC;
                        end else begin
                            n_total = 32'd0; n_hfreq = r_freq; n_hshift = w_ushift;
                            n_hclip = r_clip | w_uclip; n_hold = 1'b1;
                            n_prev = w_ushift; n_state = S_IDLE;
                        end
                    end else if (r_hold) begin
                        n_hclip = r_hclip | w_cm_clip; n_state = S_IMG;
                    end else begin
                        n_state = S_EMC;
                    end
                end
            end
            S_IMG: begin
                if (w_done) begin
                    n_s0 = w_ushift; n_hclip = r_hclip | w_uclip; n_state = S_EMH;
                end
            end
            S_EMH, S_EMC: begin
                if (w_free) begin
                    n_ovalid = 1'b1; n_oshift = w_e_shift; n_oend = w_e_end;
                    n_osat = w_e_clip | w_e_endclip | w_e_sum[32];
                    n_ototal = w_e_sum[32] ? 32'hFFFF_FFFF : w_e_sum[31:0];
                    n_total = n_ototal;
                    if (r_state == S_EMH) begin
                        n_oeos = 1'b0; n_hold = 1'b0; n_state = S_EMC;
                    end else begin
                        n_oeos = r_last; n_prev = r_shift; n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_dm <= 32'd0; r_tstep <= 32'd1;
            r_ref <= dswc_pkg::REF_RESET; r_hfreq <= 32'd0; r_hshift <= 24'sd0;
            r_hclip <= 1'b0; r_hold <= 1'b0; r_prev <= 24'sd0; r_total <= 32'd0;
            o_valid <= 1'b0;
        end else begin
            r_state <= n_state; r_hfreq <= n_hfreq; r_hshift <= n_hshift;
            r_hclip <= n_hclip; r_hold <= n_hold; r_prev <= n_prev; r_total <= n_total;
            o_valid <= n_ovalid;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    dswc_pkg::CFG_DM:        r_dm <= i_cfg_data;
                    dswc_pkg::CFG_TIME_STEP: r_tstep <= i_cfg_data;
                    dswc_pkg::CFG_REF_FREQ:  r_ref <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
        r_freq <= n_freq; r_first <= n_first; r_last <= n_last; r_clip <= n_clip;
        r_shift <= n_shift; r_s0 <= n_s0;
        o_shift_index <= n_oshift; o_window_end <= n_oend; o_window_total <= n_ototal;
        o_saturated <= n_osat; o_end_of_sweep <= n_oeos;
    end

    `DSWC_ASSERT_IMP(a_done_when_waiting, w_done, (r_state == S_CUR) || (r_state == S_IMG), "unit done while not waiting")
    `DSWC_ASSERT_IMP(a_held_emit_has_hold, r_state == S_EMH, r_hold, "held result without held channel")
    `DSWC_ASSERT_IMP(a_valid_from_emit, $rose(o_valid), $past(r_state == S_EMH) || $past(r_state == S_EMC), "result without emit")
endmodule
`default_nettype wire

[bench/dedispersion_select_window_core_tb.sv]
// testbench for the dedispersion window selector: directed, random and backpressure sweeps
// predicts every result beat and compares it in order; depends on dswc_pkg and the core
`timescale 1ns / 100ps
module dedispersion_select_window_core_tb;
    localparam longint CYCLE_LIMIT = 4000000;
    localparam int     SETTLE      = 1500;

    typedef struct {
        logic signed [23:0] shift_index;
        logic signed [23:0] window_end;
        logic [31:0]        window_total;
        logic               saturated;
        logic               end_of_sweep;
    } t_window;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic [31:0] i_freq = '0;
    logic i_first = 1'b0;
    logic i_last = 1'b0;
    logic i_ready = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [1:0] i_cfg_idx = '0;
    logic [31:0] i_cfg_data = '0;
    logic o_ready, o_valid, o_saturated, o_end_of_sweep;
    logic signed [23:0] o_shift_index, o_window_end;
    logic [31:0] o_window_total;

    dedispersion_select_window_core i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready),
        .i_freq(i_freq), .i_first(i_first), .i_last(i_last),
        .o_valid(o_valid), .i_ready(i_ready),
        .o_shift_index(o_shift_index), .o_window_end(o_window_end),
        .o_window_total(o_window_total), .o_saturated(o_saturated),
        .o_end_of_sweep(o_end_of_sweep),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // predictor copy of registers and sweep state
    logic [31:0] cur_dm = 32'd0;
    logic [31:0] cur_step = 32'd1;
    logic [31:0] cur_ref = dswc_pkg::REF_RESET;
    logic [31:0] held_freq = '0;
    int          held_shift = 0;
    bit          holding = 1'b0;
    bit          held_clip = 1'b0;
    int          prev_shift = 0;
    logic [31:0] win_sum = '0;

    t_window expected_windows[$];
    int      error_count = 0;
    int      idle_tx_pct = 0;
    int      idle_rx_pct = 0;
    int      hold_cycles = 0;
    longint  cycle_count = 0;

    bit      in_beat, out_beat;
    t_window seen;

    always @(negedge i_clk) begin
        in_beat  = i_valid && o_ready;
        out_beat = o_valid && i_ready;
        seen.shift_index  = o_shift_index;
        seen.window_end   = o_window_end;
        seen.window_total = o_window_total;
        seen.saturated    = o_saturated;
        seen.end_of_sweep = o_end_of_sweep;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else if (hold_cycles > 0) begin
            i_ready <= 1'b0;
            hold_cycles <= hold_cycles - 1;
        end else begin
            i_ready <= ($urandom_range(99) >= idle_rx_pct);
        end
    end

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("mismatch %s: got %h want %h at cycle %0d", what, got, want, cycle_count);
        error_count++;
    endtask

    always @(posedge i_clk) begin
        t_window w;
        if (i_rst_n && out_beat) begin
            if (expected_windows.size() == 0) begin
                report("unexpected beat", seen.window_total, 32'd0);
            end else begin
                w = expected_windows.pop_front();
                if (seen.shift_index !== w.shift_index)
                    report("shift_index", 32'(seen.shift_index), 32'(w.shift_index));
                if (seen.window_end !== w.window_end)
                    report("window_end", 32'(seen.window_end), 32'(w.window_end));
                if (seen.window_total !== w.window_total)
                    report("window_total", seen.window_total, w.window_total);
                if (seen.saturated !== w.saturated)
                    report("saturated", 32'(seen.saturated), 32'(w.saturated));
                if (seen.end_of_sweep !== w.end_of_sweep)
                    report("end_of_sweep", 32'(seen.end_of_sweep), 32'(w.end_of_sweep));
            end
        end
    end

    function automatic logic [63:0] clamp_freq(input longint f, inout bit clip);
        if (f < 64'd65536) begin
            clip = 1'b1;
            return 64'd65536;
        end
        if (f > 64'hFFFF_FFFF) begin
            clip = 1'b1;
            return 64'hFFFF_FFFF;
        end
        return 64'(f);
    endfunction

    function automatic logic [63:0] inv_square(input logic [63:0] f);
        logic [127:0] num, sq;
        num = 128'd1 << 95;
        sq  = {64'd0, f} * {64'd0, f};
        return 64'(num / sq);
    endfunction

    function automatic int dispersion_shift(input logic [63:0] f, inout bit clip);
        logic [63:0]  rf, mf, mr, mag, scale, t, q;
        logic [127:0] prod;
        bit           neg;
        rf    = clamp_freq(longint'(cur_ref), clip);
        mf    = inv_square(f);
        mr    = inv_square(rf);
        neg   = mf < mr;
        mag   = neg ? mr - mf : mf - mr;
        scale = 64'(cur_dm) * 64'd4150;
        t     = (cur_step == 0) ? 64'd1 : 64'(cur_step);
        prod  = {64'd0, mag} * {64'd0, scale};
        q     = 64'(prod >> 79) / t;
        if (neg) begin
            if (q > 64'd8388608) begin
                clip = 1'b1;
                return -8388608;
            end
            return -int'(q);
        end
        if (q > 64'd8388607) begin
            clip = 1'b1;
            return 8388607;
        end
        return int'(q);
    endfunction

    function automatic int smear_size(input int before_s, input int here_s);
        int s;
        s = before_s - here_s - 1;
        return (s < 0) ? 0 : s;
    endfunction

    function automatic void push_window(input int shift, input int size, input bit clip,
                                        input bit eos);
        t_window w;
        longint  wend, len;
        wend = longint'(shift) + size;
        if (wend > 8388607) begin
            wend = 8388607;
            clip = 1'b1;
        end
        len = wend - shift + 1;
        if (longint'(win_sum) + len > 64'hFFFF_FFFF) begin
            win_sum = 32'hFFFF_FFFF;
            clip = 1'b1;
        end else begin
            win_sum = win_sum + 32'(len);
        end
        w.shift_index  = 24'(shift);
        w.window_end   = 24'(wend);
        w.window_total = win_sum;
        w.saturated    = clip;
        w.end_of_sweep = eos;
        expected_windows.push_back(w);
    endfunction

    function automatic void predict_channel(input logic [31:0] freq, input bit first,
                                            input bit last);
        bit          clip, hclip;
        logic [63:0] f, cm;
        int          shift, s0;
        longint      c;
        clip  = 1'b0;
        f     = clamp_freq(longint'(freq), clip);
        shift = dispersion_shift(f, clip);
        if (first) begin
            win_sum = '0;
            holding = 1'b0;
            prev_shift = shift;
            if (last) begin
                push_window(shift, 0, clip, 1'b1);
                return;
            end
            held_freq  = 32'(f);
            held_shift = shift;
            held_clip  = clip;
            holding    = 1'b1;
            return;
        end
        if (holding) begin
            hclip = held_clip;
            c  = 2 * longint'(held_freq) - longint'(f);
            if (c < 0) c = -c;
            cm = clamp_freq(c, hclip);
            s0 = dispersion_shift(cm, hclip);
            push_window(held_shift, smear_size(s0, held_shift), hclip, 1'b0);
            holding = 1'b0;
        end
        push_window(shift, smear_size(prev_shift, shift), clip, last);
        prev_shift = shift;
    endfunction

    task automatic send_channel(input logic [31:0] freq, input bit first, input bit last);
        while ($urandom_range(99) < idle_tx_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        predict_channel(freq, first, last);
        i_valid <= 1'b1;
        i_freq  <= freq;
        i_first <= first;
        i_last  <= last;
        @(posedge i_clk);
        while (!in_beat) @(posedge i_clk);
    endtask

    task automatic drain;
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (expected_windows.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        case (idx)
            dswc_pkg::CFG_DM:        cur_dm = value;
            dswc_pkg::CFG_TIME_STEP: cur_step = value;
            dswc_pkg::CFG_REF_FREQ:  cur_ref = value;
            default: ;
        endcase
    endtask

    task automatic configure(input logic [31:0] dmv, input logic [31:0] stepv,
                             input logic [31:0] refv);
        write_reg(dswc_pkg::CFG_DM, dmv);
        write_reg(dswc_pkg::CFG_TIME_STEP, stepv);
        write_reg(dswc_pkg::CFG_REF_FREQ, refv);
    endtask

    function automatic logic [31:0] mhz(input int lo, input int hi);
        return (32'($urandom_range(hi, lo)) << 16) | 32'($urandom_range(16'hFFFF));
    endfunction

    task automatic test_directed;
        send_channel(32'd1000 << 16, 1'b0, 1'b0);
        send_channel(32'd50 << 16, 1'b0, 1'b1);
        drain();
        configure(32'd56 << 16, 32'd1000, dswc_pkg::REF_RESET);
        send_channel(dswc_pkg::FREQ_MIN, 1'b1, 1'b1);
        send_channel(dswc_pkg::FREQ_MAX, 1'b1, 1'b1);
        send_channel(32'd0, 1'b1, 1'b1);
        send_channel(32'd65535, 1'b1, 1'b1);
        send_channel(32'd80 << 16, 1'b1, 1'b0);
        send_channel(32'd70 << 16, 1'b0, 1'b0);
        send_channel(32'd60 << 16, 1'b0, 1'b1);
        send_channel(32'd40 << 16, 1'b1, 1'b0);
        send_channel(32'd30 << 16, 1'b1, 1'b0);
        send_channel(32'd20 << 16, 1'b0, 1'b1);
        send_channel(dswc_pkg::FREQ_MAX, 1'b1, 1'b0);
        send_channel(32'd70000, 1'b0, 1'b1);
        send_channel(32'd70000, 1'b1, 1'b0);
        send_channel(dswc_pkg::FREQ_MAX, 1'b0, 1'b1);
        drain();
        configure(32'hFFFF_FFFF, 32'd0, dswc_pkg::FREQ_MIN);
        send_channel(32'd200 << 16, 1'b1, 1'b0);
        send_channel(32'd100 << 16, 1'b0, 1'b1);
        drain();
        configure(32'hFFFF_FFFF, 32'hFFFF_FFFF, dswc_pkg::FREQ_MAX);
        send_channel(32'd10 << 16, 1'b1, 1'b0);
        send_channel(32'd9 << 16, 1'b0, 1'b1);
        drain();
        configure(32'hFFFF_FFFF, 32'd1, 32'd1);
        send_channel(dswc_pkg::FREQ_MIN, 1'b1, 1'b0);
        send_channel(32'd2 << 16, 1'b0, 1'b1);
        drain();
    endtask

    task automatic random_sweeps(input int items);
        int sent, n, f_mhz;
        sent = 0;
        while (sent < items) begin
            if ($urandom_range(99) < 15) begin
                send_channel($urandom(), 1'($urandom()), 1'($urandom()));
                sent++;
            end else begin
                n = $urandom_range(12, 1);
                f_mhz = $urandom_range(120, 40);
                for (int k = 0; k < n; k++) begin
                    send_channel(mhz(f_mhz - 1, f_mhz), k == 0,
                                 (k == n - 1) && ($urandom_range(9) != 0));
                    f_mhz = f_mhz - $urandom_range(3, 1);
                    if (f_mhz < 3) f_mhz = 3;
                    sent++;
                end
            end
        end
        drain();
    endtask

    task automatic test_random;
        for (int p = 0; p < 8; p++) begin
            case (p % 4)
                0: begin idle_tx_pct = 0;  idle_rx_pct = 0;  end
                1: begin idle_tx_pct = 58; idle_rx_pct = 0;  end
                2: begin idle_tx_pct = 0;  idle_rx_pct = 58; end
                default: begin idle_tx_pct = 17; idle_rx_pct = 17; end
            endcase
            case (p)
                0: configure(32'd56 << 16, 32'd1000, dswc_pkg::REF_RESET);
                1: configure($urandom_range(32'h00FF_FFFF), $urandom_range(1000000, 1),
                             mhz(30, 150));
                2: configure(32'hFFFF_FFFF, 32'hFFFF_FFFF, dswc_pkg::REF_RESET);
                3: configure(32'd0, 32'd1, dswc_pkg::FREQ_MIN);
                4: configure($urandom(), $urandom_range(100000, 1), dswc_pkg::FREQ_MAX);
                5: configure(32'd1 << 16, 32'd1, mhz(40, 120));
                6: configure($urandom_range(32'h003F_FFFF), $urandom(), $urandom());
                default: configure(32'd300 << 16, 32'd10000, mhz(100, 200));
            endcase
            random_sweeps(95);
        end
    endtask

    task automatic test_backpressure;
        idle_tx_pct = 0;
        idle_rx_pct = 0;
        configure(32'd56 << 16, 32'd500, dswc_pkg::REF_RESET);
        hold_cycles = 6000;
        send_channel(32'd90 << 16, 1'b1, 1'b0);
        for (int k = 0; k < 8; k++) send_channel(32'(88 - 4 * k) << 16, 1'b0, k == 7);
        drain();
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random();
        test_backpressure();
        if (error_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule

[filelist.f]
+incdir+hw/rtl
hw/rtl/dswc_pkg.sv
hw/rtl/dswc_shift.sv
hw/rtl/dedispersion_select_window_core.sv
bench/dedispersion_select_window_core_tb.sv
